### sv/pse_pkg.sv
package pse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_WIDTH  = 32;
  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int RESULT_W    = 32;
  localparam int STATUS_W    = 3;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int DIV_CNT_W   = $clog2(WORD_WIDTH);

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [DIV_CNT_W-1:0]  div_cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_LIT = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_END = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_DIV0  = 3'd1,
    ST_LEFT  = 3'd2,
    ST_UNDER = 3'd3,
    ST_OVER  = 3'd4,
    ST_EMPTY = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DFIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    push;
    logic    op_load;
    logic    alu_write;
    logic    pop_left;
    logic    div_start;
    logic    div_step;
    logic    div_finish;
    logic    pend_load;
    status_t pend_status;
    logic    pend_use_tos;
    logic    clear;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic   count_zero;
    logic   count_one;
    logic   count_lt2;
    logic   count_full;
    logic   tos_zero;
    logic   div_done;
    op_t    op_q;
    count_t count;
  } stat_t;

endpackage

### sv/pse_token_if.sv
interface pse_token_if;
  logic                               valid;
  logic                               ready;
  logic        [pse_pkg::OP_W-1:0]    op;
  logic signed [pse_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

### sv/pse_result_if.sv
interface pse_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [pse_pkg::RESULT_W-1:0] result;
  logic        [pse_pkg::STATUS_W-1:0] status;

  modport source (output valid, output result, output status, input ready);
  modport sink (input valid, input result, input status, output ready);
endinterface

### sv/pse_ram.sv
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/pse_ctrl.sv
module pse_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tok_valid,
  input  logic [pse_pkg::OP_W-1:0]  tok_op,
  output logic                      tok_ready,
  output logic                      res_valid,
  input  logic                      res_ready,
  input  pse_pkg::stat_t            st,
  output pse_pkg::cmd_t             cmd
);

  pse_pkg::state_t state, state_next;
  logic            res_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pse_pkg::S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.pend_status = pse_pkg::ST_OK;
    tok_ready       = 1'b0;
    res_valid_next  = res_valid && !res_ready;
    unique case (state)
      pse_pkg::S_IDLE: begin
        tok_ready = 1'b1;
        if (tok_valid) begin
          case (tok_op) inside
            pse_pkg::OP_LIT: begin
              if (st.count_full) begin
                cmd.pend_load   = 1'b1;
                cmd.pend_status = pse_pkg::ST_OVER;
                state_next      = pse_pkg::S_EMIT;
              end else begin
                cmd.push = 1'b1;
              end
            end
            pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
              if (st.count_lt2) begin
                cmd.pend_load   = 1'b1;
                cmd.pend_status = pse_pkg::ST_UNDER;
                state_next      = pse_pkg::S_EMIT;
              end else begin
                cmd.op_load = 1'b1;
                state_next  = pse_pkg::S_READ;
              end
            end
            pse_pkg::OP_END: begin
              cmd.pend_load = 1'b1;
              cmd.clear     = 1'b1;
              if (st.count_zero) begin
                cmd.pend_status = pse_pkg::ST_EMPTY;
              end else begin
                cmd.pend_use_tos = 1'b1;
                cmd.pend_status  = pse_pkg::status_t'(st.count_one ? pse_pkg::ST_OK
                                                                   : pse_pkg::ST_LEFT);
              end
              state_next = pse_pkg::S_EMIT;
            end
            default: ;
          endcase
        end
      end
      pse_pkg::S_READ: begin
        if (st.op_q == pse_pkg::OP_DIV) begin
          if (st.tos_zero) begin
            cmd.pop_left    = 1'b1;
            cmd.pend_load   = 1'b1;
            cmd.pend_status = pse_pkg::ST_DIV0;
            state_next      = pse_pkg::S_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = pse_pkg::S_DIV;
          end
        end else begin
          cmd.alu_write = 1'b1;
          state_next    = pse_pkg::S_IDLE;
        end
      end
      pse_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_next = pse_pkg::S_DFIN;
        end
      end
      pse_pkg::S_DFIN: begin
        cmd.div_finish = 1'b1;
        state_next     = pse_pkg::S_IDLE;
      end
      pse_pkg::S_EMIT: begin
        if (!res_valid || res_ready) begin
          cmd.out_load   = 1'b1;
          res_valid_next = 1'b1;
          state_next     = pse_pkg::S_IDLE;
        end
      end
      default: state_next = pse_pkg::S_IDLE;
    endcase
  end

endmodule

### sv/pse_datapath.sv
module pse_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic        [pse_pkg::OP_W-1:0]    tok_op,
  input  logic signed [pse_pkg::VALUE_W-1:0] tok_value,
  input  pse_pkg::cmd_t                      cmd,
  output pse_pkg::stat_t                     st,
  output logic signed [pse_pkg::RESULT_W-1:0] res_result,
  output logic        [pse_pkg::STATUS_W-1:0] res_status
);

  localparam int W = pse_pkg::WORD_WIDTH;

  pse_pkg::word_t    tos;
  pse_pkg::count_t   count;
  pse_pkg::op_t      op_q;
  pse_pkg::word_t    div_rem;
  pse_pkg::word_t    div_quo;
  pse_pkg::word_t    div_dvs;
  logic              div_neg;
  pse_pkg::div_cnt_t div_cnt;
  pse_pkg::word_t    pend_result;
  pse_pkg::status_t  pend_status;

  pse_pkg::word_t    rd_data;
  pse_pkg::word_t    alu;
  pse_pkg::count_t   count_m1;
  pse_pkg::count_t   count_m2;
  logic [W:0]        rem_sh;
  logic [W:0]        rem_diff;
  logic              rem_ge;

  assign count_m1 = count - pse_pkg::CNT_W'(1);
  assign count_m2 = count - pse_pkg::CNT_W'(2);

  pse_ram #(
    .WIDTH (W),
    .DEPTH (pse_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push && (count != '0)),
    .wr_addr (count_m1[pse_pkg::IDX_W-1:0]),
    .wr_data (tos),
    .rd_addr (count_m2[pse_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    case (op_q)
      pse_pkg::OP_SUB: alu = rd_data - tos;
      pse_pkg::OP_MUL: alu = W'(rd_data * tos);
      default:         alu = rd_data + tos;
    endcase
  end

  assign rem_sh   = {div_rem, div_quo[W-1]};
  assign rem_diff = rem_sh - {1'b0, div_dvs};
  assign rem_ge   = !rem_diff[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + pse_pkg::CNT_W'(1);
    end else if (cmd.alu_write || cmd.pop_left || cmd.div_start) begin
      count <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      tos <= W'(tok_value);
    end else if (cmd.alu_write) begin
      tos <= alu;
    end else if (cmd.pop_left) begin
      tos <= rd_data;
    end else if (cmd.div_finish) begin
      tos <= div_neg ? (W'(0) - div_quo) : div_quo;
    end
    if (cmd.op_load) begin
      op_q <= pse_pkg::op_t'(tok_op);
    end
    if (cmd.div_start) begin
      div_neg <= rd_data[W-1] ^ tos[W-1];
      div_quo <= rd_data[W-1] ? (W'(0) - rd_data) : rd_data;
      div_dvs <= tos[W-1] ? (W'(0) - tos) : tos;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
      div_quo <= {div_quo[W-2:0], rem_ge};
      div_cnt <= div_cnt + pse_pkg::DIV_CNT_W'(1);
    end
    if (cmd.pend_load) begin
      pend_result <= cmd.pend_use_tos ? tos : '0;
      pend_status <= cmd.pend_status;
    end
    if (cmd.out_load) begin
      res_result <= pse_pkg::RESULT_W'(pend_result);
      res_status <= pend_status;
    end
  end

  assign st.count_zero = (count == '0);
  assign st.count_one  = (count == pse_pkg::CNT_W'(1));
  assign st.count_lt2  = (count < pse_pkg::CNT_W'(2));
  assign st.count_full = (count == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH));
  assign st.tos_zero   = (tos == '0);
  assign st.div_done   = (div_cnt == pse_pkg::DIV_CNT_W'(W - 1));
  assign st.op_q       = op_q;
  assign st.count      = count;

endmodule

### sv/postfix_stack_evaluator.sv
// Postfix token evaluator on a 16-word stack of 32-bit values; the top value sits in a
// register and the words beneath it in a small RAM with a registered read. Items are
// handled one at a time. A literal is pushed on accept; add, subtract and multiply go
// through accept, then stack read and write back, and a divide through accept, stack read,
// the restoring divider that retires one quotient bit per cycle, and a finish step.
// Underflow, overflow and end tokens go from accept to S_EMIT, which loads the result
// register; divide by zero passes through S_READ first. Either is later while an earlier
// result still waits to be taken. Op codes 6 and 7 are dropped on accept.
module postfix_stack_evaluator (
  input  logic           clk,
  input  logic           rst,
  pse_token_if.sink      tok,
  pse_result_if.source   res
);

  pse_pkg::cmd_t  cmd;
  pse_pkg::stat_t st;

  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok.valid),
    .tok_op    (tok.op),
    .tok_ready (tok.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pse_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .tok_op     (tok.op),
    .tok_value  (tok.value),
    .cmd        (cmd),
    .st         (st),
    .res_result (res.result),
    .res_status (res.status)
  );

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (tok.valid && tok.ready && tok.op == pse_pkg::OP_END) |=> st.count_zero)
    else $error("stack not emptied after end item");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (tok.valid && tok.ready && tok.op == pse_pkg::OP_LIT && !st.count_full)
      |=> st.count == $past(st.count) + pse_pkg::CNT_W'(1))
    else $error("literal item did not grow the stack");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st.count <= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != pse_pkg::ST_OK && res.status != pse_pkg::ST_LEFT)
      |-> res.result == '0)
    else $error("nonzero result with error status");

endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  typedef logic [OP_W-1:0] op_code_t;

  localparam op_code_t OP_RSVD6 = 3'd6;
  localparam op_code_t OP_RSVD7 = 3'd7;

  localparam int FLAW_NONE      = 0;
  localparam int FLAW_EXTRA_LIT = 1;
  localparam int FLAW_EXTRA_OP  = 2;
  localparam int FLAW_NO_END    = 3;

  localparam int TARGET_TOKENS = 1300;
  localparam int MAX_WAIT      = 13;
  localparam int DRAIN_CYCLES  = 200;
  localparam int MAX_REPORTS   = 40;

  typedef struct {
    op_code_t op;
    word_t    value;
  } token_t;

  typedef struct {
    word_t   result;
    status_t status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;

  pse_token_if  tok_if ();
  pse_result_if res_if ();

  postfix_stack_evaluator i_dut (
    .clk (clk),
    .rst (rst),
    .tok (tok_if),
    .res (res_if)
  );

  token_t   token_queue[$];
  outcome_t outcome_queue[$];
  word_t    calc_stack[STACK_DEPTH];
  int       calc_depth;
  int       err_cnt;
  int       token_cnt;
  int       tok_wait;
  int       rdy_wait;
  int       tok_phase_left;
  int       rdy_phase_left;
  bit       tok_calm;
  bit       rdy_calm;

  always #2 clk = ~clk;

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // alternate calm stretches (no idling) with stretches of random waits
  function automatic int draw_wait(inout int phase_left, inout bit calm);
    if (phase_left == 0) begin
      calm = !calm;
      phase_left = calm ? $urandom_range(5, 40) : $urandom_range(20, 120);
    end
    phase_left--;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void push_outcome(word_t result, status_t status);
    outcome_t o;
    o.result = result;
    o.status = status;
    outcome_queue.push_back(o);
  endfunction

  function automatic word_t div_trunc(word_t l, word_t r);
    word_t ml, mr, q;
    ml = l[WORD_WIDTH-1] ? -l : l;
    mr = r[WORD_WIDTH-1] ? -r : r;
    q  = ml / mr;
    return (l[WORD_WIDTH-1] ^ r[WORD_WIDTH-1]) ? -q : q;
  endfunction

  function automatic void eval_token(op_code_t op, word_t value);
    word_t l, r;
    case (op)
      OP_LIT: begin
        if (calc_depth >= STACK_DEPTH) begin
          push_outcome('0, ST_OVER);
        end else begin
          calc_stack[calc_depth] = value;
          calc_depth++;
        end
      end
      OP_END: begin
        if (calc_depth == 0) begin
          push_outcome('0, ST_EMPTY);
        end else begin
          push_outcome(calc_stack[calc_depth-1],
                       status_t'(calc_depth == 1 ? ST_OK : ST_LEFT));
        end
        calc_depth = 0;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (calc_depth < 2) begin
          push_outcome('0, ST_UNDER);
        end else begin
          r = calc_stack[calc_depth-1];
          l = calc_stack[calc_depth-2];
          calc_depth--;
          if (op == OP_DIV && r == '0) begin
            push_outcome('0, ST_DIV0);
          end else begin
            case (op)
              OP_ADD:  calc_stack[calc_depth-1] = l + r;
              OP_SUB:  calc_stack[calc_depth-1] = l - r;
              OP_MUL:  calc_stack[calc_depth-1] = l * r;
              default: calc_stack[calc_depth-1] = div_trunc(l, r);
            endcase
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_token(op_code_t op, word_t value);
    token_t t;
    t.op    = op;
    t.value = value;
    token_queue.push_back(t);
    if (op != OP_RSVD6 && op != OP_RSVD7) begin
      token_cnt++;
    end
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5, 6:    return word_t'($urandom_range(0, 40)) - word_t'(20);
      default: return $urandom();
    endcase
  endfunction

  function automatic op_code_t rand_arith();
    case ($urandom_range(0, 3))
      0:       return OP_ADD;
      1:       return OP_SUB;
      2:       return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  function automatic void add_expression(int n_lits, int flaw);
    int lits_left, depth;
    lits_left = n_lits;
    depth     = 0;
    while (lits_left > 0 || depth > 1) begin
      if (depth >= 2 && (lits_left == 0 || depth >= STACK_DEPTH ||
                         $urandom_range(0, 2) == 0)) begin
        add_token(rand_arith(), $urandom());
        depth--;
      end else begin
        add_token(OP_LIT, rand_word());
        lits_left--;
        depth++;
      end
    end
    case (flaw)
      FLAW_EXTRA_LIT: add_token(OP_LIT, rand_word());
      FLAW_EXTRA_OP:  add_token(rand_arith(), $urandom());
      default: ;
    endcase
    if (flaw != FLAW_NO_END) begin
      add_token(OP_END, $urandom());
    end
  endfunction

  initial begin
    int kind;
    add_token(OP_END, '0);
    add_token(OP_ADD, '0);
    add_token(OP_LIT, 32'h7FFF_FFFF);
    add_token(OP_SUB, '1);
    add_token(OP_LIT, 32'd1);
    add_token(OP_ADD, '0);
    add_token(OP_LIT, '1);
    add_token(OP_DIV, '0);
    add_token(OP_LIT, '0);
    add_token(OP_DIV, '0);
    add_token(OP_END, '0);
    add_token(OP_LIT, 32'hFFFF_FFF9);
    add_token(OP_LIT, 32'd2);
    add_token(OP_DIV, '0);
    add_token(OP_LIT, 32'h8000_0000);
    add_token(OP_MUL, '0);
    add_token(OP_LIT, 32'd5);
    add_token(OP_SUB, '0);
    add_token(OP_LIT, 32'h7FFF_FFFF);
    add_token(OP_END, '0);
    add_token(OP_RSVD6, $urandom());
    add_token(OP_RSVD7, $urandom());
    add_token(OP_END, '1);

    while (token_cnt < TARGET_TOKENS) begin
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        add_expression(($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) :
                       $urandom_range(1, 6), FLAW_NONE);
      end else if (kind < 16) begin
        add_expression($urandom_range(1, 6), $urandom_range(FLAW_EXTRA_LIT, FLAW_NO_END));
      end else if (kind == 16) begin
        repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 3)) begin
          add_token(OP_LIT, rand_word());
        end
        if ($urandom_range(0, 1) == 1) begin
          add_token(rand_arith(), $urandom());
        end
        add_token(OP_END, $urandom());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_token(op_code_t'($urandom_range(0, 7)), $urandom());
        end
      end
    end
  end

  always @(posedge clk) begin
    token_t t;
    if (rst) begin
      tok_if.valid <= 1'b0;
      tok_wait = 0;
    end else begin
      if (tok_if.valid && tok_if.ready) begin
        eval_token(tok_if.op, tok_if.value);
      end
      if (!tok_if.valid || tok_if.ready) begin
        if (tok_wait > 0 || token_queue.size() == 0) begin
          if (tok_wait > 0) begin
            tok_wait--;
          end
          tok_if.valid <= 1'b0;
        end else begin
          t = token_queue.pop_front();
          tok_if.valid <= 1'b1;
          tok_if.op    <= t.op;
          tok_if.value <= t.value;
          tok_wait = draw_wait(tok_phase_left, tok_calm);
        end
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      rdy_wait = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (outcome_queue.size() == 0) begin
          note_error($sformatf("unexpected item: result %0d status %0d",
                               res_if.result, res_if.status));
        end else begin
          want = outcome_queue.pop_front();
          if (res_if.result !== want.result) begin
            note_error($sformatf("result mismatch: expected %0d, actual %0d",
                                 $signed(want.result), res_if.result));
          end
          if (res_if.status !== want.status) begin
            note_error($sformatf("status mismatch: expected %0d, actual %0d",
                                 want.status, res_if.status));
          end
        end
        rdy_wait = draw_wait(rdy_phase_left, rdy_calm);
      end
      if (rdy_wait > 0) begin
        rdy_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    tok_if.valid = 1'b0;
    tok_if.op    = OP_LIT;
    tok_if.value = '0;
    res_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (token_queue.size() != 0 || tok_if.valid) @(posedge clk);
    while (outcome_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
